// ----- design/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear-probe hash set
// Key width, register map, state codes and the result word of the back end.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 11;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ADD    = 1'b1;

  typedef enum logic [2:0] {
    FR_IDLE = 3'b001,
    FR_DIV  = 3'b010,
    FR_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [3:0] {
    BK_CLEAR = 4'b0001,
    BK_IDLE  = 4'b0010,
    BK_READ  = 4'b0100,
    BK_CHECK = 4'b1000
  } back_state_t;

  typedef struct packed {
    logic present;
    logic inserted;
    logic table_full;
  } result_t;

endpackage

// ----- design/lph_ram.sv -----
// ----------------------------------------------------------------------------
// lph_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lph_front.sv -----
// ----------------------------------------------------------------------------
// lph_front: input stage of the hash set
// Takes a word, forms the key magnitude and works out the home slot with a
// bit-serial remainder, then hands the word to the queue.
// ----------------------------------------------------------------------------
module lph_front #(
  parameter int AW = 10,
  parameter int SW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     enable,
  input  logic [SW-1:0]            size,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [lph_pkg::KEY_W-1:0] value,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic                     push_add,
  output logic [lph_pkg::KEY_W-1:0] push_key,
  output logic [AW-1:0]            push_home
);
  import lph_pkg::*;

  front_state_t     state, state_next;
  logic             add;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] dividend;
  logic [SW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [SW:0]      trial;
  logic [KEY_W-1:0] mag;

  // The magnitude of the most negative key wraps to 2^31, which is wanted.
  assign mag   = value[KEY_W-1] ? (KEY_W'(0) - value) : value;
  assign trial = {rem, dividend[KEY_W-1]};

  assign in_ready   = (state == FR_IDLE) && enable;
  assign push_valid = (state == FR_PUSH);
  assign push_add   = add;
  assign push_key   = key;
  assign push_home  = rem[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (in_valid && in_ready) state_next = FR_DIV;
      end
      FR_DIV: begin
        if (cnt == CNT_W'(KEY_W - 1)) state_next = FR_PUSH;
      end
      FR_PUSH: begin
        if (push_ready) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      FR_IDLE: begin
        if (in_valid && in_ready) begin
          add      <= action;
          key      <= value;
          dividend <= mag;
          rem      <= '0;
          cnt      <= '0;
        end
      end
      FR_DIV: begin
        if (trial >= {1'b0, size}) begin
          rem <= SW'(trial - {1'b0, size});
        end else begin
          rem <= trial[SW-1:0];
        end
        dividend <= {dividend[KEY_W-2:0], 1'b0};
        cnt      <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- design/lph_queue.sv -----
// ----------------------------------------------------------------------------
// lph_queue: two-entry queue between front and back
// Lets the front hash the next word while the back is still probing.
// ----------------------------------------------------------------------------
module lph_queue #(
  parameter int W = 43
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
    if (do_push) entry[wr_ptr] <= push_data;
  end

endmodule

// ----- design/lph_back.sv -----
// ----------------------------------------------------------------------------
// lph_back: probe engine of the hash set
// Clears the table after reset, then probes from the home slot for each
// queued word, stores new keys and holds the result in an output register.
// ----------------------------------------------------------------------------
module lph_back #(
  parameter int AW    = 10,
  parameter int SW    = 11,
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [SW-1:0]             size,
  output logic                      clearing,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  logic                      pop_add,
  input  logic [lph_pkg::KEY_W-1:0] pop_key,
  input  logic [AW-1:0]             pop_home,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lph_pkg::result_t          result
);
  import lph_pkg::*;

  back_state_t      state, state_next;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    steps;
  logic [AW-1:0]    last_step;
  logic             add;
  logic [KEY_W-1:0] key;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W:0]   wdata;
  logic [KEY_W:0]   rdata;
  logic             slot_used;
  logic             hit;
  logic             out_free;

  lph_ram #(.WIDTH(KEY_W + 1), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign slot_used = rdata[KEY_W];
  assign hit       = slot_used && (rdata[KEY_W-1:0] == key);
  assign last_step = AW'(size - SW'(1));
  assign out_free  = !out_valid || out_ready;
  assign clearing  = (state == BK_CLEAR);
  assign pop_ready = (state == BK_IDLE) && out_free;

  // During the clearing pass idx sweeps the table; afterwards a write only
  // ever fills the empty slot just read.
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {1'b1, key};
    if (state == BK_CLEAR) begin
      we    = 1'b1;
      wdata = '0;
    end else if (state == BK_CHECK && !slot_used && add) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (idx == AW'(DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (pop_valid && pop_ready) state_next = BK_READ;
      end
      BK_READ:  state_next = BK_CHECK;
      BK_CHECK: begin
        if (!slot_used || hit || steps == last_step) begin
          state_next = BK_IDLE;
        end else begin
          state_next = BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        BK_CLEAR: begin
          idx <= idx + AW'(1);
        end
        BK_IDLE: begin
          if (pop_valid && pop_ready) idx <= pop_home;
        end
        BK_CHECK: begin
          if (!slot_used || hit || steps == last_step) begin
            out_valid <= 1'b1;
          end else if ({1'b0, idx} + (AW+1)'(1) == (AW+1)'(size)) begin
            idx <= '0;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
    case (state)
      BK_IDLE: begin
        if (pop_valid && pop_ready) begin
          add   <= pop_add;
          key   <= pop_key;
          steps <= '0;
        end
      end
      BK_CHECK: begin
        steps <= steps + AW'(1);
        if (!slot_used) begin
          result.present    <= 1'b0;
          result.inserted   <= add;
          result.table_full <= 1'b0;
        end else if (hit) begin
          result.present    <= 1'b1;
          result.inserted   <= 1'b0;
          result.table_full <= 1'b0;
        end else begin
          result.present    <= 1'b0;
          result.inserted   <= 1'b0;
          result.table_full <= add;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/linear_probe_hash_set.sv -----
// After reset the block clears the slot table and takes no word while it
// does so; the table_size register can be written meanwhile. Each word then
// passes through the front end, where the home slot is found by a
// one-bit-per-cycle remainder of the key magnitude by the table size. The
// back end takes the word from the queue and then, for each slot probed,
// does a registered table read (BK_READ) and then a compare (BK_CHECK).
// A two-entry queue lets the two ends overlap.
// ----------------------------------------------------------------------------
// linear_probe_hash_set: open-addressing hash set with linear probing
// Looks up or adds signed 32-bit keys; the active table size is set over APB.
// ----------------------------------------------------------------------------
module linear_probe_hash_set #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lph_pkg::PADDR_W-1:0] paddr,
  input  logic [lph_pkg::APB_W-1:0]   pwdata,
  output logic [lph_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic signed [lph_pkg::KEY_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        present,
  output logic                        inserted,
  output logic                        table_full
);
  import lph_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam int QW = 1 + KEY_W + AW;

  logic [CFG_W-1:0] table_size;
  logic [CW-1:0]    size_ext;
  logic [SW-1:0]    size;
  logic             clearing;
  logic             push_valid, push_ready, push_add;
  logic [KEY_W-1:0] push_key;
  logic [AW-1:0]    push_home;
  logic             pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;
  result_t          result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? APB_W'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_SIZE) begin
      table_size <= pwdata[CFG_W-1:0];
    end
  end

  // A zero size acts as one, and sizes beyond the table saturate.
  always_comb begin
    size_ext = CW'(table_size);
    if (size_ext == '0) begin
      size_ext = CW'(1);
    end else if (size_ext > CW'(TABLE_DEPTH)) begin
      size_ext = CW'(TABLE_DEPTH);
    end
    size = size_ext[SW-1:0];
  end

  lph_front #(.AW(AW), .SW(SW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (!clearing),
    .size       (size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_add   (push_add),
    .push_key   (push_key),
    .push_home  (push_home)
  );

  lph_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_add, push_key, push_home}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lph_back #(.AW(AW), .SW(SW), .DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .size      (size),
    .clearing  (clearing),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_add   (pop_data[QW-1]),
    .pop_key   (pop_data[AW +: KEY_W]),
    .pop_home  (pop_data[AW-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign present    = result.present;
  assign inserted   = result.inserted;
  assign table_full = result.table_full;

endmodule

// ----- bench/tb_linear_probe_hash_set.sv -----
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_set: self-checking bench for the linear-probe hash set
// Drives lookups and adds through a directed table, then random phases at
// several table sizes; checks each result against the table or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_set;
  import lph_pkg::*;

  localparam int DEPTH = 1024;
  localparam int PHASE_WORDS = 106;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic act;
    logic [KEY_W-1:0] key;
    bit chk;
    result_t res;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, act_in;
  logic signed [KEY_W-1:0] key_in;
  logic out_valid, out_ready, present, inserted, table_full;

  // Local copy of the table and the size register.
  logic [KEY_W-1:0] slot_key [DEPTH];
  bit slot_taken [DEPTH];
  logic [CFG_W-1:0] size_reg;

  result_t pending_q[$];
  logic [KEY_W-1:0] key_pool[$];
  int errors;
  bit calm;
  bit hold_req;
  bit hold_done;

  linear_probe_hash_set #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .action(act_in), .value(key_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .present(present), .inserted(inserted), .table_full(table_full)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic result_t probe_and_update(logic act, logic [KEY_W-1:0] key);
    int unsigned span;
    logic [KEY_W-1:0] mag;
    int unsigned idx;
    result_t r;
    bit found;
    bit have_free;
    int unsigned free_idx;
    span = size_reg;
    if (span == 0) span = 1;
    if (span > DEPTH) span = DEPTH;
    mag = key[KEY_W-1] ? (~key + 1'b1) : key;
    idx = mag % span;
    found = 0;
    have_free = 0;
    free_idx = 0;
    for (int unsigned n = 0; n < span; n++) begin
      if (!slot_taken[idx]) begin
        have_free = 1;
        free_idx = idx;
        break;
      end
      if (slot_key[idx] == key) begin
        found = 1;
        break;
      end
      idx = (idx + 1 >= span) ? 0 : idx + 1;
    end
    r = '0;
    r.present = found;
    if (act == ACT_ADD && !found) begin
      if (have_free) begin
        slot_key[free_idx] = key;
        slot_taken[free_idx] = 1;
        r.inserted = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  // Offers one word, holding it until accepted, and books its result.
  task automatic send_word(logic act, logic [KEY_W-1:0] key, bit chk, result_t typed);
    result_t r;
    if (!calm && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    act_in = act;
    key_in = key;
    do @(posedge clk); while (!in_ready);
    r = probe_and_update(act, key);
    pending_q.push_back(chk ? typed : r);
    if (act == ACT_ADD && key_pool.size() < 200) key_pool.push_back(key);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_size(logic [APB_W-1:0] data);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {REG_TABLE_SIZE, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    size_reg = data[CFG_W-1:0];
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== size_reg) begin
      errors++;
      if (errors <= 10)
        $display("size readback: expected %0d, got %0d", size_reg, prdata[CFG_W-1:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 35 && key_pool.size() != 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 65) return KEY_W'($signed($urandom_range(40)) - 20);
    if (r < 72) begin
      case ($urandom_range(2))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        default: return 32'h8000_0001;
      endcase
    end
    return $urandom;
  endfunction

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready = calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %b%b%b", present, inserted, table_full);
      end else begin
        want = pending_q.pop_front();
        if (present !== want.present || inserted !== want.inserted ||
            table_full !== want.table_full) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected p%b i%b f%b, got p%b i%b f%b",
                     want.present, want.inserted, want.table_full,
                     present, inserted, table_full);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [APB_W-1:0] sizes[$];
    int guard;
    errors = 0; calm = 0; hold_req = 0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; act_in = 0; key_in = '0;
    size_reg = SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      slot_key[i] = '0;
      slot_taken[i] = 0;
    end

    rows = '{
      '{ROW_WORD, ACT_LOOKUP, 32'd0,        1, 3'b000},
      '{ROW_WORD, ACT_ADD,    32'd0,        1, 3'b010},
      '{ROW_WORD, ACT_ADD,    32'd0,        1, 3'b100},
      '{ROW_WORD, ACT_LOOKUP, 32'd0,        1, 3'b100},
      '{ROW_WORD, ACT_LOOKUP, 32'h80000000, 1, 3'b000},
      '{ROW_WORD, ACT_ADD,    32'h80000000, 1, 3'b010},
      '{ROW_WORD, ACT_ADD,    32'h7fffffff, 1, 3'b010},
      '{ROW_WORD, ACT_ADD,    32'hffffffff, 1, 3'b010},
      '{ROW_WORD, ACT_ADD,    32'd1,        0, 3'b000},
      '{ROW_WORD, ACT_LOOKUP, 32'hffffffff, 1, 3'b100},
      '{ROW_WORD, ACT_LOOKUP, 32'd1024,     0, 3'b000},
      '{ROW_WORD, ACT_ADD,    -32'sd1024,   0, 3'b000},
      '{ROW_SIZE, ACT_LOOKUP, 32'd0,        0, 3'b000},
      '{ROW_WORD, ACT_ADD,    32'd5,        1, 3'b001},
      '{ROW_WORD, ACT_LOOKUP, 32'd0,        1, 3'b100},
      '{ROW_WORD, ACT_LOOKUP, 32'd7,        1, 3'b000},
      '{ROW_SIZE, ACT_LOOKUP, 32'hffff_f7ff, 0, 3'b000},
      '{ROW_WORD, ACT_LOOKUP, -32'sd1024,   1, 3'b100},
      '{ROW_WORD, ACT_ADD,    32'h55555555, 0, 3'b000},
      '{ROW_WORD, ACT_ADD,    32'haaaaaaaa, 0, 3'b000},
      '{ROW_SIZE, ACT_LOOKUP, 32'd2,        0, 3'b000},
      '{ROW_WORD, ACT_ADD,    32'd3,        1, 3'b001},
      '{ROW_WORD, ACT_LOOKUP, 32'h80000000, 1, 3'b100}
    };
    sizes = '{1, 2047, 7, 0, 64, 1024, 13, 2, 300};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The size register may be written while the table is being cleared.
    write_size(32'd1024);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_SIZE) begin
        drain();
        write_size(rows[i].key);
      end else begin
        send_word(rows[i].act, rows[i].key, rows[i].chk, rows[i].res);
      end
    end

    foreach (sizes[p]) begin
      drain();
      write_size((APB_W'($urandom_range(1 << 20)) << CFG_W) | sizes[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        calm = (p == 2);
        if (p == 4 && n == 10) hold_req = 1'b1;
        send_word($urandom_range(99) < 55 ? ACT_ADD : ACT_LOOKUP, pick_key(), 0, '0);
      end
    end
    calm = 0;
    in_valid = 1'b0;

    guard = 0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (pending_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lph_pkg.sv
design/lph_ram.sv
design/lph_front.sv
design/lph_queue.sv
design/lph_back.sv
design/linear_probe_hash_set.sv
bench/tb_linear_probe_hash_set.sv
